// File: hdl/itew_pkg.sv
// Shared types and constants for the integer-to-English word token block.
// No dependencies; every other file in hdl/ refers to this package.
`default_nettype none

package itew_pkg;

    localparam int VALUE_W     = 31;
    localparam int WORD_W      = 5;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int SHIFT_W     = 32;              // value padded to an even bit count
    localparam int CONV_CYCLES = SHIFT_W / 2;     // two binary bits folded in per cycle
    localparam int CNT_W       = $clog2(CONV_CYCLES);
    localparam int STEP_W      = 3;

    localparam logic [WORD_W-1:0] CODE_ZERO      = 5'd0;
    localparam logic [WORD_W-1:0] CODE_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] CODE_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] CODE_THOUSAND  = 5'd29;
    localparam logic [WORD_W-1:0] CODE_MILLION   = 5'd30;
    localparam logic [WORD_W-1:0] CODE_BILLION   = 5'd31;

    // word slots within one three-digit group, in emission order
    localparam logic [STEP_W-1:0] STEP_HDIG  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_HUND  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TENS  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_UNIT  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SCALE = 3'd4;

    localparam logic [1:0] GRP_UNITS    = 2'd0;
    localparam logic [1:0] GRP_THOUSAND = 2'd1;
    localparam logic [1:0] GRP_MILLION  = 2'd2;
    localparam logic [1:0] GRP_BILLION  = 2'd3;

    typedef struct packed {
        logic              load;
        logic              conv;
        logic              emit;
        logic [1:0]        grp;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic              present;
        logic              last;
        logic [WORD_W-1:0] code;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/itew_if.sv
// Valid/ready channel interfaces for the input value and the word tokens.
// Depends on itew_pkg for field widths.
`default_nettype none

interface itew_in_if;
    logic                          valid;
    logic                          ready;
    logic [itew_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itew_out_if;
    logic                          valid;
    logic                          ready;
    logic [itew_pkg::WORD_W-1:0]   word_code;
    logic                          last_word;

    modport source (output valid, output word_code, output last_word, input ready);
    modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

`default_nettype wire

// File: hdl/integer_to_english_word_tokens.sv
// Spells a non-negative 31-bit integer as a run of English word codes.
// Depends on itew_pkg, itew_if, itew_ctrl and itew_datapath.
//
// Usage:
//   i_in  : valid/ready channel carrying value (31 bits). A transaction
//           happens on a rising edge with valid and ready both high.
//   o_out : valid/ready channel carrying word_code (5 bits) and last_word;
//           last_word is set on the final word of each number.
// Timing: after an input transaction the value goes through a binary-to-BCD
//   converter that folds in two bits per cycle. The sequencer then walks
//   four digit groups of five word slots each, one slot per cycle while
//   the output register can take a word. A new value is taken once the
//   walk of the previous one has finished, even while its last word still
//   waits in the output register.
// Stalls: while a word waits, a low o_out.ready holds the walk on the
//   current slot; nothing is lost and the output word stays put until taken.
// Reset: synchronous, active low; clears the controller and the output
//   valid flag, dropping any item in progress.
`default_nettype none

module integer_to_english_word_tokens (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    itew_in_if.sink           i_in,
    itew_out_if.source        o_out
);

    itew_pkg::t_cmd  w_cmd;
    itew_pkg::t_stat w_stat;

    itew_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    itew_datapath u_datapath (
        .i_clk   (i_clk),
        .i_value (i_in.value),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_word  (o_out.word_code),
        .o_last  (o_out.last_word)
    );

endmodule

`default_nettype wire

// File: hdl/itew_datapath.sv
// Datapath: binary-to-BCD converter (two bits per cycle), group word decode
// and the output word register. Depends on itew_pkg.
`default_nettype none

module itew_datapath (
    input  wire logic                          i_clk,
    input  wire logic [itew_pkg::VALUE_W-1:0]  i_value,
    input  wire itew_pkg::t_cmd                i_cmd,
    output itew_pkg::t_stat                    o_stat,
    output logic [itew_pkg::WORD_W-1:0]        o_word,
    output logic                               o_last
);

    localparam int BCD_W = itew_pkg::BCD_W;

    logic [itew_pkg::SHIFT_W-1:0] r_shift;
    logic [BCD_W-1:0]             r_bcd;
    logic [itew_pkg::WORD_W-1:0]  r_word;
    logic                         r_last;

    logic [BCD_W-1:0] w_bcd_half;
    logic [BCD_W-1:0] w_bcd_full;
    logic [47:0]      w_pad;
    logic [3:0]       w_h;
    logic [3:0]       w_t;
    logic [3:0]       w_u;
    logic [3:0]       w_gnz;
    logic [3:0]       w_low_mask;
    logic             w_all_zero;
    logic             w_lower_zero;
    logic             w_t_ge2;
    logic [7:0]       w_p;
    logic [7:0]       w_after;
    logic [itew_pkg::WORD_W-1:0] w_code;
    logic [itew_pkg::WORD_W-1:0] w_scale;

    // one double-dabble step: add 3 to every digit >= 5, then shift in a bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                                  input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = b;
        for (int i = 0; i < itew_pkg::DIGITS; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    assign w_bcd_half = dabble(r_bcd, r_shift[itew_pkg::SHIFT_W-1]);
    assign w_bcd_full = dabble(w_bcd_half, r_shift[itew_pkg::SHIFT_W-2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= {1'b0, i_value};
            r_bcd   <= '0;
        end else if (i_cmd.conv) begin
            r_shift <= {r_shift[itew_pkg::SHIFT_W-3:0], 2'b00};
            r_bcd   <= w_bcd_full;
        end
        if (i_cmd.emit) begin
            r_word <= o_stat.code;
            r_last <= o_stat.last;
        end
    end

    assign w_pad      = {8'd0, r_bcd};
    assign w_all_zero = (r_bcd == '0);

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            w_gnz[g] = |w_pad[12*g +: 12];
        end
    end

    always_comb begin
        unique case (i_cmd.grp)
            itew_pkg::GRP_UNITS: begin
                w_h = w_pad[11:8];  w_t = w_pad[7:4];   w_u = w_pad[3:0];
                w_scale = itew_pkg::CODE_ZERO;
            end
            itew_pkg::GRP_THOUSAND: begin
                w_h = w_pad[23:20]; w_t = w_pad[19:16]; w_u = w_pad[15:12];
                w_scale = itew_pkg::CODE_THOUSAND;
            end
            itew_pkg::GRP_MILLION: begin
                w_h = w_pad[35:32]; w_t = w_pad[31:28]; w_u = w_pad[27:24];
                w_scale = itew_pkg::CODE_MILLION;
            end
            default: begin
                w_h = w_pad[47:44]; w_t = w_pad[43:40]; w_u = w_pad[39:36];
                w_scale = itew_pkg::CODE_BILLION;
            end
        endcase
    end

    assign w_low_mask   = (4'b0001 << i_cmd.grp) - 4'd1;
    assign w_lower_zero = ((w_gnz & w_low_mask) == 4'd0);
    assign w_t_ge2      = (w_t >= 4'd2);

    // which word slots of the current group carry a word
    always_comb begin
        w_p = '0;
        if (w_all_zero) begin
            // input zero spells as the single word Zero
            w_p[itew_pkg::STEP_HDIG] = (i_cmd.grp == itew_pkg::GRP_UNITS);
        end else begin
            w_p[itew_pkg::STEP_HDIG]  = (w_h != 4'd0);
            w_p[itew_pkg::STEP_HUND]  = (w_h != 4'd0);
            w_p[itew_pkg::STEP_TENS]  = (w_t != 4'd0) || (w_u != 4'd0);
            w_p[itew_pkg::STEP_UNIT]  = w_t_ge2 && (w_u != 4'd0);
            w_p[itew_pkg::STEP_SCALE] = (i_cmd.grp != itew_pkg::GRP_UNITS)
                                        && w_gnz[i_cmd.grp];
        end
    end

    always_comb begin
        unique case (i_cmd.step)
            itew_pkg::STEP_HDIG:  w_code = {1'b0, w_h};
            itew_pkg::STEP_HUND:  w_code = itew_pkg::CODE_HUNDRED;
            itew_pkg::STEP_TENS:  w_code = w_t_ge2 ? itew_pkg::CODE_TENS_BASE + {1'b0, w_t}
                                         : (w_t[0] ? 5'd10 + {1'b0, w_u} : {1'b0, w_u});
            itew_pkg::STEP_UNIT:  w_code = {1'b0, w_u};
            default:              w_code = w_scale;
        endcase
    end

    assign w_after        = w_p >> (i_cmd.step + 3'd1);
    assign o_stat.present = w_p[i_cmd.step];
    assign o_stat.last    = w_p[i_cmd.step] && (w_after == 8'd0) && w_lower_zero;
    assign o_stat.code    = w_code;

    assign o_word = r_word;
    assign o_last = r_last;

endmodule

`default_nettype wire

// File: hdl/itew_ctrl.sv
// Controller: sequences load, BCD conversion and the group/word-slot walk,
// and owns the output valid flag. Depends on itew_pkg.
`default_nettype none

module itew_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    input  wire itew_pkg::t_stat i_stat,
    output itew_pkg::t_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [itew_pkg::CNT_W-1:0] CNT_LAST = itew_pkg::CNT_W'(itew_pkg::CONV_CYCLES - 1);

    logic [1:0]                    r_state, n_state;
    logic [itew_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [1:0]                    r_grp, n_grp;
    logic [itew_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          r_out_valid, n_out_valid;
    logic                          w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_grp       = r_grp;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.load  = 1'b0;
        o_cmd.conv  = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.grp   = r_grp;
        o_cmd.step  = r_step;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_grp   = itew_pkg::GRP_BILLION;
                    n_step  = itew_pkg::STEP_HDIG;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // one word slot per cycle once the output register can take it
                if (w_out_free) begin
                    o_cmd.emit = i_stat.present;
                    if (i_stat.present) begin
                        n_out_valid = 1'b1;
                    end
                    if (r_step == itew_pkg::STEP_SCALE) begin
                        n_step = itew_pkg::STEP_HDIG;
                        if (r_grp == itew_pkg::GRP_UNITS) begin
                            n_state = S_IDLE;
                        end else begin
                            n_grp = r_grp - 2'd1;
                        end
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_grp       <= itew_pkg::GRP_UNITS;
            r_step      <= itew_pkg::STEP_HDIG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_grp       <= n_grp;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_EMIT))
        else $error("word emitted outside the emit phase");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    a_conv_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_cnt == CNT_LAST) |=>
            (r_state == S_EMIT && r_grp == itew_pkg::GRP_BILLION
             && r_step == itew_pkg::STEP_HDIG))
        else $error("conversion did not hand over to the billions group");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= itew_pkg::STEP_SCALE)
        else $error("word slot index out of range");

endmodule

`default_nettype wire

// File: verif/integer_to_english_word_tokens_tb.sv
// Self-checking testbench for integer_to_english_word_tokens.
// Drives values over itew_in_if, predicts each word run and checks it on itew_out_if.
// Depends on itew_pkg, itew_if and the block RTL.

module integer_to_english_word_tokens_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WORD_W       = itew_pkg::WORD_W;
    localparam int          VALUE_W      = itew_pkg::VALUE_W;
    localparam int          RESET_CYCLES = 10;
    localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off to fill the block
    localparam int          IDLE_LIMIT   = 3000;  // cycles with no transaction on either side
    localparam int          TAIL_CYCLES  = 64;
    localparam int          MAX_PRINTS   = 40;
    localparam int unsigned VALUE_MAX    = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic              last;
    } t_word;

    logic clk;
    logic rst_n;

    itew_in_if  in_ch ();
    itew_out_if out_ch ();

    integer_to_english_word_tokens dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_word word_q[$];    // words still due from the block, oldest first
    t_word spelled[$];   // scratch run for the value being spelled
    int    err_count;
    bit    src_idle_en;
    bit    sink_idle_en;
    bit    hold_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void put_word(input logic [WORD_W-1:0] code);
        spelled.push_back('{code: code, last: 1'b0});
    endfunction

    // English spelling of one value, appended to the queue of due words
    function automatic void spell_value(input logic [VALUE_W-1:0] v);
        int unsigned       n;
        int unsigned       grp;
        int unsigned       rest;
        int unsigned       grp_div[4];
        logic [WORD_W-1:0] grp_scale[4];
        t_word             w;

        grp_div   = '{1, 1000, 1000000, 1000000000};
        grp_scale = '{itew_pkg::CODE_ZERO, itew_pkg::CODE_THOUSAND,
                      itew_pkg::CODE_MILLION, itew_pkg::CODE_BILLION};
        n = {1'b0, v};
        spelled.delete();
        if (n == 0) begin
            put_word(itew_pkg::CODE_ZERO);
        end else begin
            for (int s = int'(itew_pkg::GRP_BILLION); s >= int'(itew_pkg::GRP_UNITS); s--) begin
                grp  = (n / grp_div[s]) % 1000;
                rest = grp % 100;
                if (grp != 0) begin
                    if (grp >= 100) begin
                        put_word(WORD_W'(grp / 100));
                        put_word(itew_pkg::CODE_HUNDRED);
                    end
                    if (rest >= 20) begin
                        put_word(WORD_W'(itew_pkg::CODE_TENS_BASE + rest / 10));
                        if (rest % 10 != 0)
                            put_word(WORD_W'(rest % 10));
                    end else if (rest != 0) begin
                        put_word(WORD_W'(rest));
                    end
                    if (s != int'(itew_pkg::GRP_UNITS))
                        put_word(grp_scale[s]);
                end
            end
        end
        w = spelled.pop_back();
        w.last = 1'b1;
        spelled.push_back(w);
        foreach (spelled[i])
            word_q.push_back(spelled[i]);
    endfunction

    // one three-digit group, biased toward the special shapes
    function automatic int unsigned rand_group();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(1, 19);
            2: return $urandom_range(2, 9) * 10;
            3: return $urandom_range(1, 9) * 100;
            4: return $urandom_range(1, 9) * 100 + $urandom_range(20, 99);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        longint unsigned total;
        case ($urandom_range(0, 3))
            0: return VALUE_W'($urandom);
            1: return VALUE_W'($urandom_range(0, 999));
            default: begin
                total = longint'($urandom_range(0, 2)) * 1000000000
                      + longint'(rand_group()) * 1000000
                      + longint'(rand_group()) * 1000
                      + longint'(rand_group());
                if (total > VALUE_MAX)
                    total = total - 1000000000;
                return VALUE_W'(total);
            end
        endcase
    endfunction

    // offer one value and wait for its transaction; valid stays up for a follow-on value
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        spell_value(v);
    endtask

    task automatic test_directed();
        int unsigned vals[$];
        vals = '{0, 1, 7, 13, 19, 20, 40, 21, 99, 100, 300, 101, 115, 999, 1000, 1001,
                 10000, 100000, 1000000, 1000010, 1000000000, 2000000000, 1234567891,
                 VALUE_MAX, 32'h4000_0000};
        foreach (vals[i])
            send_value(VALUE_W'(vals[i]));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_value(rand_value());
    endtask

    // receiver holds off while values keep coming, so the input side must stall
    task automatic test_backpressure(input int count);
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        repeat (count) send_value(rand_value());
        src_idle_en = 1'b1;
    endtask

    task automatic test_no_idle(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (count) send_value(rand_value());
    endtask

    // output ready: random stall bursts, plus the long hold-off on request
    initial begin : sink_drive
        int n;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
                hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : word_check
        t_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (word_q.size() == 0) begin
                report_mismatch($sformatf("word %0d last %0b with nothing due",
                                          out_ch.word_code, out_ch.last_word));
            end else begin
                want = word_q.pop_front();
                if (out_ch.word_code !== want.code)
                    report_mismatch($sformatf("word_code %0d, expected %0d",
                                              out_ch.word_code, want.code));
                if (out_ch.last_word !== want.last)
                    report_mismatch($sformatf("last_word %0b, expected %0b (word %0d)",
                                              out_ch.last_word, want.last, want.code));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        err_count    = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(170);
        test_backpressure(24);
        test_random(170);
        test_no_idle(30);

        in_ch.valid <= 1'b0;
        while (word_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
